// File: src/extended_compare_interval_timer_assert.svh
// Assertion macros shared by the timer checker
`ifndef EXTENDED_COMPARE_INTERVAL_TIMER_ASSERT_SVH
`define EXTENDED_COMPARE_INTERVAL_TIMER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define ECIT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define ECIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ecit_pkg.sv
// Shared widths, mode codes and register indexes of the compare interval timer
`default_nettype none

package ecit_pkg;

	// Field widths
	localparam int MODE_W      = 2;
	localparam int CMP_W       = 8;
	localparam int LIMIT_W     = 16;
	localparam int COUNT_OUT_W = 8;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Mode codes; the unused fourth code behaves as toggle PWM
	localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PWM      = 2'd2;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MATCH_LIMIT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ON_CMP      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OFF_CMP     = 3'd4;

	// Register reset values
	localparam logic [CMP_W-1:0]   CMP_RESET   = 8'hFF;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'h0000;

endpackage

`default_nettype wire

// File: src/extended_compare_interval_timer.sv
// Top level of the compare-match interval timer with periodic, single-shot and PWM modes
`default_nettype none

// Compare-match interval timer. Each input transfer carries at most one prescaled
// tick and a restart request; each produces exactly one result transfer with the
// fire and match flags, the PWM pin level, the run state and the low 8 bits of the
// counter after that item. The timer takes one item every clock cycle while in_ready
// is high: the counter, match counter and compare state update in the cycle of the
// input transfer and the result lands in a one-deep output register the same edge,
// so the result appears in the cycle after its input. in_ready stays high while that
// register is empty or is being drained, so a stalled output holds the input side
// only while the result waits. Configuration writes are registered and act from the
// next match or restart.
module extended_compare_interval_timer
	import ecit_pkg::*;
#(
	parameter int COUNTER_BITS     = 8,
	parameter int MATCH_COUNT_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration writes
	input  wire logic                   wr_en,
	input  wire logic [CFG_INDEX_W-1:0] wr_index,
	input  wire logic [CFG_DATA_W-1:0]  wr_data,
	// Input channel
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   tick,
	input  wire logic                   restart,
	// Result channel
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        fire,
	output logic                        compare_match,
	output logic                        pin_level,
	output logic                        running,
	output logic [COUNT_OUT_W-1:0]      count_now
);

	// Configuration registers
	logic [MODE_W-1:0]  mode_q;
	logic [CMP_W-1:0]   interval_cmp_q;
	logic [LIMIT_W-1:0] match_limit_q;
	logic [CMP_W-1:0]   on_cmp_q;
	logic [CMP_W-1:0]   off_cmp_q;

	// Timer state
	logic [COUNTER_BITS-1:0]     cnt_q, cnt_d;
	logic [MATCH_COUNT_BITS-1:0] mcnt_q, mcnt_d;
	logic [COUNTER_BITS-1:0]     act_cmp_q, act_cmp_d;
	logic                        phase_high_q, phase_high_d;
	logic                        pin_q, pin_d;
	logic                        run_q, run_d;

	// Per-item flags
	logic fire_d, match_d;

	// Decoded views of the configuration
	logic                        pwm_mode;
	logic [MATCH_COUNT_BITS-1:0] limit;
	logic [COUNTER_BITS-1:0]     interval_cmp_ext, on_cmp_ext, off_cmp_ext;

	logic in_xfer;

	assign in_ready = !out_valid || out_ready;
	assign in_xfer  = in_valid && in_ready;

	assign pwm_mode         = (mode_q >= MODE_PWM);
	assign limit            = MATCH_COUNT_BITS'(match_limit_q);
	assign interval_cmp_ext = COUNTER_BITS'(interval_cmp_q);
	assign on_cmp_ext       = COUNTER_BITS'(on_cmp_q);
	assign off_cmp_ext      = COUNTER_BITS'(off_cmp_q);

	// Decode configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_PERIODIC;
			interval_cmp_q <= CMP_RESET;
			match_limit_q  <= LIMIT_RESET;
			on_cmp_q       <= CMP_RESET;
			off_cmp_q      <= CMP_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:        mode_q         <= wr_data[MODE_W-1:0];
				REG_INTERVAL:    interval_cmp_q <= wr_data[CMP_W-1:0];
				REG_MATCH_LIMIT: match_limit_q  <= wr_data[LIMIT_W-1:0];
				REG_ON_CMP:      on_cmp_q       <= wr_data[CMP_W-1:0];
				REG_OFF_CMP:     off_cmp_q      <= wr_data[CMP_W-1:0];
				default: ;
			endcase
		end
	end

	// Work out the next timer state for the item on the input
	always_comb begin
		cnt_d        = cnt_q;
		mcnt_d       = mcnt_q;
		act_cmp_d    = act_cmp_q;
		phase_high_d = phase_high_q;
		pin_d        = pin_q;
		run_d        = run_q;
		fire_d       = 1'b0;
		match_d      = 1'b0;
		if (restart) begin
			// Restart drops any tick in the same item
			cnt_d        = '0;
			mcnt_d       = '0;
			pin_d        = 1'b0;
			phase_high_d = 1'b1;
			act_cmp_d    = pwm_mode ? on_cmp_ext : interval_cmp_ext;
			run_d        = 1'b1;
		end else if (tick && run_q) begin
			if (cnt_q == act_cmp_q) begin
				match_d = 1'b1;
				cnt_d   = '0;
				if (pwm_mode) begin
					// Toggle the pin and swap to the other phase's compare
					pin_d        = !pin_q;
					phase_high_d = !phase_high_q;
					act_cmp_d    = phase_high_q ? off_cmp_ext : on_cmp_ext;
				end else begin
					act_cmp_d = interval_cmp_ext;
					if (mcnt_q < limit) begin
						mcnt_d = mcnt_q + 1'b1;
					end else begin
						fire_d = 1'b1;
						mcnt_d = '0;
						if (mode_q == MODE_SINGLE) begin
							run_d = 1'b0;
						end
					end
				end
			end else begin
				// Advance, wrapping at the counter width
				cnt_d = cnt_q + 1'b1;
			end
		end
	end

	// Hold timer state; update on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			mcnt_q       <= '0;
			act_cmp_q    <= '0;
			phase_high_q <= 1'b1;
			pin_q        <= 1'b0;
			run_q        <= 1'b0;
		end else if (in_xfer) begin
			cnt_q        <= cnt_d;
			mcnt_q       <= mcnt_d;
			act_cmp_q    <= act_cmp_d;
			phase_high_q <= phase_high_d;
			pin_q        <= pin_d;
			run_q        <= run_d;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_xfer) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			fire          <= fire_d;
			compare_match <= match_d;
			pin_level     <= pin_d;
			running       <= run_d;
			count_now     <= cnt_d[COUNT_OUT_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: src/ecit_checker.sv
// Port-level checker for the compare interval timer and its bind
`default_nettype none

`include "extended_compare_interval_timer_assert.svh"

module ecit_checker
	import ecit_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   tick,
	input wire logic                   restart,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic                   fire,
	input wire logic                   compare_match,
	input wire logic                   pin_level,
	input wire logic                   running,
	input wire logic [COUNT_OUT_W-1:0] count_now
);

	logic in_xfer;
	logic quiet_item;

	assign in_xfer    = in_valid && in_ready;
	assign quiet_item = !tick && !restart;

	// A stalled result must hold until its transfer
	`ECIT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(fire) && $stable(compare_match) && $stable(pin_level) && $stable(running) && $stable(count_now), "result changed while stalled")

	// A waiting result blocks the input side
	`ECIT_ASSERT_SAME(a_no_overrun, clk, arst_n, out_valid && !out_ready, !in_ready, "input taken over a stalled result")

	// A restart shows a running, cleared timer in its result
	`ECIT_ASSERT_NEXT(a_restart_result, clk, arst_n, in_xfer && restart, out_valid && running && !fire && !compare_match && !pin_level && (count_now == '0), "restart result wrong")

	// An item with neither tick nor restart cannot match or fire
	`ECIT_ASSERT_NEXT(a_quiet_item, clk, arst_n, in_xfer && quiet_item, out_valid && !fire && !compare_match, "match without a tick")

endmodule

bind extended_compare_interval_timer ecit_checker u_ecit_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.tick          (tick),
	.restart       (restart),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.fire          (fire),
	.compare_match (compare_match),
	.pin_level     (pin_level),
	.running       (running),
	.count_now     (count_now)
);

`default_nettype wire
